// File: rtl/flash_command_sequencer_assert.svh
// Assertion macros for the flash command sequencer.
`ifndef FLASH_COMMAND_SEQUENCER_ASSERT_SVH
`define FLASH_COMMAND_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FLSQ_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define FLSQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/flsq_pkg.sv
`default_nettype none

package flsq_pkg;

   localparam int DIRTY_W = 35;
   // 8k granules in the longest erase range
   localparam int LANES = 8;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_PROG  = 2'd1,
      ACT_ERASE = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   localparam logic [1:0] CSR_MANUFACTURER_ID  = 2'd0;
   localparam logic [1:0] CSR_DEVICE_CODE      = 2'd1;
   localparam logic [1:0] CSR_BOOT_BLOCK_FIRST = 2'd2;
   localparam logic [1:0] CSR_DUAL_CHIP        = 2'd3;

   typedef struct packed {
      logic [7:0] manufacturer_id;
      logic [7:0] device_code;
      logic [4:0] boot_block_first;
      logic       dual_chip;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      manufacturer_id:  8'h98,
      device_code:      8'h2F,
      boot_block_first: 5'd31,
      dual_chip:        1'b1
   };

   typedef struct packed {
      logic        func;
      logic [23:0] bus_addr;
      logic [7:0]  bus_data;
   } item_type;

   typedef struct packed {
      action_type         action;
      logic               chip_sel;
      logic [21:0]        target_addr;
      logic [7:0]         program_byte;
      logic [16:0]        erase_length;
      logic [5:0]         block_index;
      logic [7:0]         read_byte;
      logic               id_mode;
      logic               save_pending;
      logic [DIRTY_W-1:0] dirty_low_chip;
      logic [DIRTY_W-1:0] dirty_high_chip;
   } rsp_type;

   // Block number of a chip-local address; the boot 64k is split 32k/8k/8k/16k.
   function automatic logic [5:0] block_of(input logic [20:0] a, input logic [4:0] bbf);
      logic [5:0] n;
      n = {1'b0, a[20:16]};
      if (a[20:16] == bbf) begin
         if (a[15:0] < 16'h8000)      n = {1'b0, bbf};
         else if (a[15:0] < 16'hA000) n = {1'b0, bbf} + 6'd1;
         else if (a[15:0] < 16'hC000) n = {1'b0, bbf} + 6'd2;
         else                         n = {1'b0, bbf} + 6'd3;
      end
      return n;
   endfunction

   function automatic logic [20:0] block_start(input logic [5:0] n, input logic [4:0] bbf);
      logic [20:0] a;
      logic [5:0]  d;
      d = n - {1'b0, bbf};
      if (n >= {1'b0, bbf}) begin
         a = {bbf, 16'h0000};
         if (d >= 6'd1) a = a + 21'h008000;
         if (d >= 6'd2) a = a + 21'h002000;
         if (d >= 6'd3) a = a + 21'h002000;
      end else begin
         a = {n[4:0], 16'h0000};
      end
      return a;
   endfunction

   function automatic logic [16:0] block_len(input logic [5:0] n, input logic [4:0] bbf);
      logic [16:0] len;
      logic [5:0]  d;
      d   = n - {1'b0, bbf};
      len = 17'h10000;
      if (n >= {1'b0, bbf}) begin
         if (d == 6'd0)                    len = 17'h08000;
         else if (d == 6'd1 || d == 6'd2)  len = 17'h02000;
         else if (d == 6'd3)               len = 17'h04000;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

// File: rtl/flsq_erase_mark.sv
`default_nettype none

module flsq_erase_mark
   import flsq_pkg::*;
#(
   parameter int BLOCKS_PER_CHIP = 35
) (
   input  wire logic [4:0]                 boot_block_first,
   input  wire logic [20:0]                erase_start,
   input  wire logic [16:0]                erase_len,
   output logic      [BLOCKS_PER_CHIP-1:0] erase_mask
);

   logic [3:0] granules;

   assign granules = erase_len[16:13];

   // One lane per 8k granule of the range; mark every block a granule touches, except block zero.
   always_comb begin
      logic [20:0] lane_addr;
      logic [5:0]  blk;
      erase_mask = '0;
      for (int k = 0; k < LANES; k++) begin
         lane_addr = erase_start + {8'(k), 13'h0000};
         blk       = block_of(lane_addr, boot_block_first);
         if (4'(k) < granules && blk != 6'd0) begin
            for (int i = 0; i < BLOCKS_PER_CHIP; i++) begin
               if (blk == 6'(i)) erase_mask[i] = 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/flsq_seq.sv
`default_nettype none

module flsq_seq
   import flsq_pkg::*;
#(
   parameter int BLOCKS_PER_CHIP = 35
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     step_en,
   input  wire item_type item,
   output rsp_type       result
);

   typedef enum logic [2:0] {
      STEP_1 = 3'd1,
      STEP_2 = 3'd2,
      STEP_3 = 3'd3,
      STEP_4 = 3'd4,
      STEP_5 = 3'd5,
      STEP_6 = 3'd6
   } step_type;

   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_INFO  = 2'd1,
      PEND_PROG  = 2'd2,
      PEND_ERASE = 2'd3
   } pend_type;

   localparam logic [15:0] ADDR_UNLOCK1   = 16'h5555;
   localparam logic [15:0] ADDR_UNLOCK2   = 16'h2AAA;
   localparam logic [7:0]  DATA_UNLOCK1   = 8'hAA;
   localparam logic [7:0]  DATA_UNLOCK2   = 8'h55;
   localparam logic [7:0]  OP_ERASE_SETUP = 8'h80;
   localparam logic [7:0]  OP_ID          = 8'h90;
   localparam logic [7:0]  OP_PROGRAM     = 8'hA0;
   localparam logic [7:0]  OP_RESET       = 8'hF0;
   localparam logic [7:0]  OP_CHIP_ERASE  = 8'h10;
   localparam logic [7:0]  OP_BLOCK_ERASE = 8'h30;
   localparam logic [7:0]  OP_BLOCK_ALT   = 8'h50;
   localparam logic [7:0]  ID_PROTECT     = 8'h00;
   localparam logic [7:0]  ID_EXTRA       = 8'h80;
   localparam logic [2:0]  WIN_LOW        = 3'b001;
   localparam logic [2:0]  WIN_HIGH       = 3'b100;

   step_type                   step_ff, step_in;
   pend_type                   pend_ff, pend_in;
   logic                       save_ff, save_in;
   logic [BLOCKS_PER_CHIP-1:0] dirty_lo_ff, dirty_lo_in;
   logic [BLOCKS_PER_CHIP-1:0] dirty_hi_ff, dirty_hi_in;

   logic [15:0]                a16;
   logic [7:0]                 data;
   logic                       chip;
   logic [5:0]                 blk;
   logic [20:0]                erase_start;
   logic [16:0]                erase_len;
   logic [BLOCKS_PER_CHIP-1:0] erase_mask;
   logic [BLOCKS_PER_CHIP-1:0] prog_mask;

   assign a16         = item.bus_addr[15:0];
   assign data        = item.bus_data;
   assign chip        = item.bus_addr[23];
   assign blk         = block_of(item.bus_addr[20:0], cfg.boot_block_first);
   assign erase_start = block_start(blk, cfg.boot_block_first);
   assign erase_len   = block_len(blk, cfg.boot_block_first);

   flsq_erase_mark #(
      .BLOCKS_PER_CHIP (BLOCKS_PER_CHIP)
   ) u_erase_mark (
      .boot_block_first (cfg.boot_block_first),
      .erase_start      (erase_start),
      .erase_len        (erase_len),
      .erase_mask       (erase_mask)
   );

   always_comb begin
      for (int i = 0; i < BLOCKS_PER_CHIP; i++) begin
         prog_mask[i] = (blk == 6'(i));
      end
   end

   always_comb begin
      logic [BLOCKS_PER_CHIP-1:0] set_mask;
      set_mask = '0;
      step_in  = step_ff;
      pend_in  = pend_ff;
      save_in  = save_ff;
      result   = '0;

      if (item.func) begin
         step_in       = STEP_1;
         pend_in       = PEND_INFO;
         result.action = ACT_READ;
         case (item.bus_addr[1:0])
            2'd0:    result.read_byte = cfg.manufacturer_id;
            2'd1:    result.read_byte = cfg.device_code;
            2'd2:    result.read_byte = ID_PROTECT;
            default: result.read_byte = ID_EXTRA;
         endcase
      end else if (!(chip && !cfg.dual_chip)) begin
         // upper window with no second chip: drop the beat untouched
         case (step_ff)
            STEP_1: begin
               if (a16 == ADDR_UNLOCK1 && data == DATA_UNLOCK1) begin
                  step_in = STEP_2;
               end else begin
                  if (data == OP_RESET) save_in = 1'b1;
                  step_in = STEP_1;
               end
               pend_in = PEND_NONE;
            end
            STEP_2: begin
               step_in = (a16 == ADDR_UNLOCK2 && data == DATA_UNLOCK2) ? STEP_3 : STEP_1;
               pend_in = PEND_NONE;
            end
            STEP_5: begin
               step_in = (a16 == ADDR_UNLOCK2 && data == DATA_UNLOCK2) ? STEP_6 : STEP_1;
               pend_in = PEND_NONE;
            end
            STEP_3: begin
               step_in = STEP_1;
               pend_in = PEND_NONE;
               if (a16 == ADDR_UNLOCK1) begin
                  if (data == OP_ERASE_SETUP) begin
                     step_in = STEP_4;
                  end else if (data == OP_RESET) begin
                     save_in = 1'b1;
                  end else if (data == OP_ID) begin
                     step_in = STEP_4;
                     pend_in = PEND_INFO;
                  end else if (data == OP_PROGRAM) begin
                     step_in = STEP_4;
                     pend_in = PEND_PROG;
                  end
               end
            end
            STEP_4: begin
               if (pend_ff == PEND_PROG) begin
                  if ((item.bus_addr[23:21] == WIN_LOW || item.bus_addr[23:21] == WIN_HIGH)
                      && blk != 6'd0) begin
                     set_mask            = prog_mask;
                     result.action       = ACT_PROG;
                     result.chip_sel     = chip;
                     result.target_addr  = {chip, item.bus_addr[20:0]};
                     result.program_byte = data;
                     result.block_index  = blk;
                  end
                  step_in = STEP_1;
                  save_in = 1'b1;
               end else begin
                  step_in = (a16 == ADDR_UNLOCK1 && data == DATA_UNLOCK1) ? STEP_5 : STEP_1;
               end
               pend_in = PEND_NONE;
            end
            STEP_6: begin
               step_in = STEP_1;
               if (a16 == ADDR_UNLOCK1 && data == OP_CHIP_ERASE) begin
                  pend_in = PEND_ERASE;
               end else if (data == OP_BLOCK_ERASE || data == OP_BLOCK_ALT) begin
                  pend_in = PEND_ERASE;
                  save_in = 1'b1;
                  if (blk != 6'd0) begin
                     set_mask            = erase_mask;
                     result.action       = ACT_ERASE;
                     result.chip_sel     = chip;
                     result.target_addr  = {chip, erase_start};
                     result.erase_length = erase_len;
                     result.block_index  = blk;
                  end
               end else begin
                  pend_in = PEND_NONE;
               end
            end
            default: begin
               step_in = STEP_1;
               pend_in = PEND_NONE;
            end
         endcase
      end

      dirty_lo_in = dirty_lo_ff | (chip ? '0 : set_mask);
      dirty_hi_in = dirty_hi_ff | (chip ? set_mask : '0);

      // status fields show the state after this beat
      result.id_mode         = (pend_in == PEND_INFO);
      result.save_pending    = save_in;
      result.dirty_low_chip  = DIRTY_W'(dirty_lo_in);
      result.dirty_high_chip = DIRTY_W'(dirty_hi_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= STEP_1;
         pend_ff     <= PEND_NONE;
         save_ff     <= 1'b0;
         dirty_lo_ff <= '0;
         dirty_hi_ff <= '0;
      end else if (step_en) begin
         step_ff     <= step_in;
         pend_ff     <= pend_in;
         save_ff     <= save_in;
         dirty_lo_ff <= dirty_lo_in;
         dirty_hi_ff <= dirty_hi_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/flash_command_sequencer.sv
`default_nettype none

// Flash command sequencer: takes one bus access per beat on the req_ side and
// returns exactly one result beat on the rsp_ side for it, in order. Write
// accesses (tuser 0) walk the unlock sequence 5555/AA, 2AAA/55, command at
// 5555, and turn byte-program and block-erase commands into program or erase
// requests for an external array, with the block number, flat address (chip
// one offset by 0x200000) and erase length; ID reads (tuser 1) return maker,
// device, protect or extra (0x80) bytes. Every result also carries the ID-mode
// flag, the sticky save-pending flag and the per-block dirty bits of both chips
// as they stand after that access. Throughput is one beat per clock unless the
// result side stalls; the input register holds each request and the result
// register the combinational sequencer update for it. The input register doubles
// as a skid stage, so one request is still taken while a result waits. The
// user must write the configuration registers through csr_ only while no beat
// is in flight; the block does not enforce this. Out of reset they hold maker
// 0x98, device 0x2F, boot area at block 31 and a second chip present.

module flash_command_sequencer
   import flsq_pkg::*;
#(
   parameter int BLOCKS_PER_CHIP = 35
) (
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // bus_addr[23:0], bus_data[31:24]
   input  wire logic [0:0]   req_tuser,   // func[0]

   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [135:0] rsp_tdata,   // chip_sel[0], target_addr[22:1],
                                          // program_byte[30:23], erase_length[47:31],
                                          // block_index[53:48], read_byte[61:54],
                                          // id_mode[62], save_pending[63],
                                          // dirty_low_chip[98:64],
                                          // dirty_high_chip[133:99], zero pad
   output logic      [1:0]   rsp_tuser,   // action[1:0]

   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [7:0]   csr_wdata
);

`include "flash_command_sequencer_assert.svh"

   cfg_type  cfg_ff, cfg_in;

   logic     in_valid_ff, in_valid_in;
   item_type in_item_ff, in_item_in;
   logic     out_valid_ff, out_valid_in;
   rsp_type  rsp_ff, rsp_in;

   logic     req_fire;
   logic     advance;
   logic     step_en;
   rsp_type  seq_result;

   // Configuration: plain register writes, no read-back.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MANUFACTURER_ID:  cfg_in.manufacturer_id  = csr_wdata;
            CSR_DEVICE_CODE:      cfg_in.device_code      = csr_wdata;
            CSR_BOOT_BLOCK_FIRST: cfg_in.boot_block_first = csr_wdata[4:0];
            CSR_DUAL_CHIP:        cfg_in.dual_chip        = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // The result register drains when empty or taken; the input register
   // advances into it whenever it drains, and takes a new beat when free.
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign step_en    = in_valid_ff && advance;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign in_item_in   = req_fire ? item_type'{func:     req_tuser[0],
                                               bus_addr: req_tdata[23:0],
                                               bus_data: req_tdata[31:24]}
                                  : in_item_ff;
   assign out_valid_in = step_en || (out_valid_ff && !rsp_tready);
   assign rsp_in       = step_en ? seq_result : rsp_ff;

   flsq_seq #(
      .BLOCKS_PER_CHIP (BLOCKS_PER_CHIP)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .step_en (step_en),
      .item    (in_item_ff),
      .result  (seq_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff <= in_item_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = rsp_ff.action;
   assign rsp_tdata  = {2'b00,
                        rsp_ff.dirty_high_chip,
                        rsp_ff.dirty_low_chip,
                        rsp_ff.save_pending,
                        rsp_ff.id_mode,
                        rsp_ff.read_byte,
                        rsp_ff.block_index,
                        rsp_ff.erase_length,
                        rsp_ff.program_byte,
                        rsp_ff.target_addr,
                        rsp_ff.chip_sel};

   // A held request must not be lost while the result side stalls.
   `FLSQ_ASSERT_NEXT(a_skid_holds, clock, reset, in_valid_ff && !advance, in_valid_ff, "held request dropped")

   // Any program or erase leaves the save-pending flag set.
   `FLSQ_ASSERT_IMPLY(a_save_on_change, clock, reset, out_valid_ff && (rsp_ff.action == ACT_PROG || rsp_ff.action == ACT_ERASE), rsp_ff.save_pending, "change without save pending")

   // An ID read always leaves the sequencer in ID mode.
   `FLSQ_ASSERT_IMPLY(a_read_id_mode, clock, reset, out_valid_ff && rsp_ff.action == ACT_READ, rsp_ff.id_mode, "ID read outside ID mode")

endmodule

`default_nettype wire

// File: verif/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import flsq_pkg::*;

   localparam int BLOCKS_PER_CHIP = 35;
   // Generous bound on a clean run.
   localparam int CYCLE_LIMIT     = 200000;
   // Long receiver hold-off, enough to back the block up into its input.
   localparam int RSP_HOLD_CYCLES = 300;
   // Beats per random phase.
   localparam int PHASE_BEATS     = 130;

   // Bus cycle values of the unlock protocol.
   localparam logic [15:0] ADDR_UNLOCK_A     = 16'h5555;
   localparam logic [15:0] ADDR_UNLOCK_B     = 16'h2AAA;
   localparam logic [7:0]  DATA_UNLOCK_A     = 8'hAA;
   localparam logic [7:0]  DATA_UNLOCK_B     = 8'h55;
   localparam logic [7:0]  CMD_SETUP_ERASE   = 8'h80;
   localparam logic [7:0]  CMD_READ_ID       = 8'h90;
   localparam logic [7:0]  CMD_PROGRAM       = 8'hA0;
   localparam logic [7:0]  CMD_RESET         = 8'hF0;
   localparam logic [7:0]  CMD_CHIP_ERASE    = 8'h10;
   localparam logic [7:0]  CMD_BLOCK_ERASE_A = 8'h30;
   localparam logic [7:0]  CMD_BLOCK_ERASE_B = 8'h50;

   localparam bit FUNC_WRITE = 1'b0;
   localparam bit FUNC_READ  = 1'b1;

   // Command held by the sequencer between bus cycles.
   typedef enum bit [1:0] {
      PEND_NONE    = 2'd0,
      PEND_ID      = 2'd1,
      PEND_PROGRAM = 2'd2,
      PEND_ERASE   = 2'd3
   } pending_kind;

   // Mirror of the sequencer: tracks its state and configuration, and keeps
   // the results still owed by the block, oldest first.
   class flash_tracker;
      int unsigned maker;
      int unsigned device;
      int unsigned boot_first;
      bit          second_chip;

      int unsigned       step;
      pending_kind       held_cmd;
      logic [34:0]       dirty_lo;
      logic [34:0]       dirty_hi;
      bit                save;
      rsp_type           results_owed[$];
      int                failures;

      function new();
         maker       = 32'(CFG_RESET.manufacturer_id);
         device      = 32'(CFG_RESET.device_code);
         boot_first  = 32'(CFG_RESET.boot_block_first);
         second_chip = CFG_RESET.dual_chip;
         step        = 1;
         held_cmd    = PEND_NONE;
         dirty_lo    = '0;
         dirty_hi    = '0;
         save        = 1'b0;
         failures    = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [7:0] value);
         case (idx)
            CSR_MANUFACTURER_ID:  maker = 32'(value);
            CSR_DEVICE_CODE:      device = 32'(value);
            CSR_BOOT_BLOCK_FIRST: boot_first = 32'(value[4:0]);
            CSR_DUAL_CHIP:        second_chip = value[0];
            default: ;
         endcase
      endfunction

      // Block number of a chip-local address, boot 64k split 32k/8k/8k/16k.
      function int unsigned block_number(int unsigned a);
         int unsigned base;
         int unsigned off;
         base = boot_first << 16;
         a    = a & 32'h1FFFFF;
         if (a >= base) begin
            off = a - base;
            if (off < 32'h8000) return boot_first;
            if (off < 32'hA000) return boot_first + 1;
            if (off < 32'hC000) return boot_first + 2;
            if (off < 32'h10000) return boot_first + 3;
         end
         return a >> 16;
      endfunction

      function void mark_dirty(bit chip, int unsigned n);
         if (n >= BLOCKS_PER_CHIP) return;
         if (chip) dirty_hi[n] = 1'b1;
         else dirty_lo[n] = 1'b1;
      endfunction

      // Advance the sequencer by one bus access and return the result beat.
      function rsp_type sequence_access(bit func, int unsigned addr, int unsigned data);
         rsp_type     r;
         int unsigned a16;
         int unsigned flat;
         int unsigned n;
         int unsigned m;
         int unsigned base;
         int unsigned span;
         int unsigned off;
         bit          chip;
         bit          in_window;
         r   = '0;
         a16 = addr & 32'hFFFF;
         if (func) begin
            // ID reads answer in any state and leave the sequencer in ID mode
            step     = 1;
            held_cmd = PEND_ID;
            r.action = ACT_READ;
            case (addr & 3)
               0:       r.read_byte = maker[7:0];
               1:       r.read_byte = device[7:0];
               2:       r.read_byte = 8'h00;
               default: r.read_byte = 8'h80;
            endcase
         end else if (addr >= 32'h800000 && !second_chip) begin
            // no second chip: the upper window is dead, state untouched
         end else begin
            case (step)
               1: begin
                  if (a16 == ADDR_UNLOCK_A && data == DATA_UNLOCK_A) step = 2;
                  else begin
                     if (data == CMD_RESET) save = 1'b1;
                     step = 1;
                  end
                  held_cmd = PEND_NONE;
               end
               2, 5: begin
                  step = (a16 == ADDR_UNLOCK_B && data == DATA_UNLOCK_B) ? step + 1 : 1;
                  held_cmd = PEND_NONE;
               end
               3: begin
                  step     = 1;
                  held_cmd = PEND_NONE;
                  if (a16 == ADDR_UNLOCK_A) begin
                     if (data == CMD_SETUP_ERASE) step = 4;
                     else if (data == CMD_RESET) save = 1'b1;
                     else if (data == CMD_READ_ID) begin
                        step     = 4;
                        held_cmd = PEND_ID;
                     end else if (data == CMD_PROGRAM) begin
                        step     = 4;
                        held_cmd = PEND_PROGRAM;
                     end
                  end
               end
               4: begin
                  if (held_cmd == PEND_PROGRAM) begin
                     flat      = 0;
                     chip      = 1'b0;
                     in_window = 1'b1;
                     if (addr >= 32'h200000 && addr < 32'h400000) flat = addr - 32'h200000;
                     else if (addr >= 32'h800000 && addr < 32'hA00000) begin
                        flat = addr - 32'h600000;
                        chip = 1'b1;
                     end else in_window = 1'b0;
                     if (in_window) begin
                        n = block_number(flat);
                        // block zero is protected: drop the program
                        if (n != 0) begin
                           mark_dirty(chip, n);
                           r.action       = ACT_PROG;
                           r.chip_sel     = chip;
                           r.target_addr  = flat[21:0];
                           r.program_byte = data[7:0];
                           r.block_index  = n[5:0];
                        end
                     end
                     step = 1;
                     save = 1'b1;
                  end else begin
                     step = (a16 == ADDR_UNLOCK_A && data == DATA_UNLOCK_A) ? 5 : 1;
                  end
                  held_cmd = PEND_NONE;
               end
               6: begin
                  step = 1;
                  if (a16 == ADDR_UNLOCK_A && data == CMD_CHIP_ERASE) begin
                     // chip erase is accepted but causes no action
                     held_cmd = PEND_ERASE;
                  end else if (data == CMD_BLOCK_ERASE_A || data == CMD_BLOCK_ERASE_B) begin
                     chip     = (addr >= 32'h800000);
                     n        = block_number(addr);
                     held_cmd = PEND_ERASE;
                     save     = 1'b1;
                     if (n != 0) begin
                        // blocks from the boot start on take the boot-area layout
                        if (n >= boot_first) begin
                           base = boot_first << 16;
                           if (n - boot_first >= 1) base += 32'h8000;
                           if (n - boot_first >= 2) base += 32'h2000;
                           if (n - boot_first >= 3) base += 32'h2000;
                           case (n - boot_first)
                              0:       span = 32'h8000;
                              1, 2:    span = 32'h2000;
                              3:       span = 32'h4000;
                              default: span = 32'h10000;
                           endcase
                        end else begin
                           base = n << 16;
                           span = 32'h10000;
                        end
                        if (chip) base += 32'h200000;
                        // mark every block but block zero that the range touches, 8k at a time
                        for (off = 0; off < span; off += 32'h2000) begin
                           m = block_number(base + off);
                           if (m != 0) mark_dirty(chip, m);
                        end
                        r.action       = ACT_ERASE;
                        r.chip_sel     = chip;
                        r.target_addr  = base[21:0];
                        r.erase_length = span[16:0];
                        r.block_index  = n[5:0];
                     end
                  end else begin
                     held_cmd = PEND_NONE;
                  end
               end
               default: begin
                  step     = 1;
                  held_cmd = PEND_NONE;
               end
            endcase
         end
         r.id_mode         = (held_cmd == PEND_ID);
         r.save_pending    = save;
         r.dirty_low_chip  = dirty_lo;
         r.dirty_high_chip = dirty_hi;
         return r;
      endfunction

      function void note_request(bit func, logic [23:0] addr, logic [7:0] data);
         results_owed.push_back(sequence_access(func, 32'(addr), 32'(data)));
      endfunction

      function void compare(string field, logic [34:0] want, logic [34:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %h, got %h", field, want, got);
            failures++;
         end
      endfunction

      function void check_response(logic [1:0] act, logic [135:0] d);
         rsp_type want;
         if (results_owed.size() == 0) begin
            $error("result beat with no access outstanding");
            failures++;
            return;
         end
         want = results_owed.pop_front();
         compare("action", want.action, act);
         compare("chip_sel", want.chip_sel, d[0]);
         compare("target_addr", want.target_addr, d[22:1]);
         compare("program_byte", want.program_byte, d[30:23]);
         compare("erase_length", want.erase_length, d[47:31]);
         compare("block_index", want.block_index, d[53:48]);
         compare("read_byte", want.read_byte, d[61:54]);
         compare("id_mode", want.id_mode, d[62]);
         compare("save_pending", want.save_pending, d[63]);
         compare("dirty_low_chip", want.dirty_low_chip, d[98:64]);
         compare("dirty_high_chip", want.dirty_high_chip, d[133:99]);
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [31:0]  req_tdata;   // bus_addr[23:0], bus_data[31:24]
   logic [0:0]   req_tuser;   // func[0]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [135:0] rsp_tdata;   // chip_sel, target_addr, program_byte, erase_length,
                              // block_index, read_byte, id_mode, save_pending,
                              // dirty_low_chip, dirty_high_chip, zero pad
   logic [1:0]   rsp_tuser;   // action[1:0]
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [7:0]   csr_wdata;

   flash_tracker tracker = new();

   // Shared knobs between the sender and the receiver, and run counters.
   bit hold_rsp = 1'b0;   // ask the receiver for one long hold-off
   bit no_idle  = 1'b0;   // suspend random idling on both sides
   int accesses_sent = 0; // beats the block actually acts on
   int cycle_count = 0;

   flash_command_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver: drop tready now and then, and hold it low for a long stretch
   // when asked so that the block backs up and stalls its input.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(99) >= 6);
         end
      end
   end

   // Check every result beat against the oldest owed result.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_response(rsp_tuser, rsp_tdata);
   end

   // Offer one access beat and hold it until taken; idle first at random.
   task automatic send_access(bit func, logic [23:0] addr, logic [7:0] data);
      while (!no_idle && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {data, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_request(func, addr, data);
      // writes to a dead upper window do not count as work
      if (func == FUNC_READ || !addr[23] || tracker.second_chip) accesses_sent++;
   endtask

   // Upper address byte of an unlock cycle: random, but mostly kept out of a
   // dead upper window so that sequences get through.
   function automatic logic [7:0] command_page();
      logic [7:0] p;
      p = 8'($urandom);
      if (!tracker.second_chip && $urandom_range(9) != 0) p[7] = 1'b0;
      return p;
   endfunction

   // Program or erase address: weighted towards the boot area and block zero,
   // in either window, with the odd fully random address.
   function automatic logic [23:0] flash_target();
      logic [20:0] off;
      int unsigned pick;
      off  = 21'($urandom);
      pick = $urandom_range(3);
      if (pick == 0) off[20:16] = 5'(tracker.boot_first);
      else if (pick == 1) off[20:17] = 4'h0;
      pick = $urandom_range(9);
      if (pick < 4) return {3'b001, off};
      if (pick < 8) return {3'b100, off};
      return 24'($urandom);
   endfunction

   task automatic unlock();
      send_access(FUNC_WRITE, {command_page(), ADDR_UNLOCK_A}, DATA_UNLOCK_A);
      send_access(FUNC_WRITE, {command_page(), ADDR_UNLOCK_B}, DATA_UNLOCK_B);
   endtask

   task automatic issue_command(logic [7:0] code);
      unlock();
      send_access(FUNC_WRITE, {command_page(), ADDR_UNLOCK_A}, code);
   endtask

   // Pause the sender until every owed result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.results_owed.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.set_register(idx, value);
   endtask

   task automatic configure(logic [7:0] maker, logic [7:0] device, logic [4:0] boot, bit dual);
      write_register(CSR_MANUFACTURER_ID, maker);
      write_register(CSR_DEVICE_CODE, device);
      write_register(CSR_BOOT_BLOCK_FIRST, {3'b000, boot});
      write_register(CSR_DUAL_CHIP, {7'b0, dual});
      csr_we <= 1'b0;
   endtask

   // Mostly well-formed command sequences with random content, the rest
   // broken sequences and noise.
   task automatic run_random(int beats);
      int          stop_at;
      int unsigned pick;
      logic [7:0]  erase_data;
      stop_at = accesses_sent + beats;
      while (accesses_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            issue_command(CMD_PROGRAM);
            send_access(FUNC_WRITE, flash_target(), 8'($urandom_range(255)));
         end else if (pick < 58) begin
            issue_command(CMD_SETUP_ERASE);
            unlock();
            pick = $urandom_range(9);
            if (pick == 0) begin
               send_access(FUNC_WRITE, {command_page(), ADDR_UNLOCK_A}, CMD_CHIP_ERASE);
            end else begin
               if (pick == 1) erase_data = 8'($urandom);
               else erase_data = pick[0] ? CMD_BLOCK_ERASE_A : CMD_BLOCK_ERASE_B;
               send_access(FUNC_WRITE, flash_target(), erase_data);
            end
         end else if (pick < 66) begin
            issue_command(CMD_READ_ID);
            repeat ($urandom_range(1, 3)) begin
               send_access(FUNC_READ, 24'($urandom), 8'($urandom));
            end
         end else if (pick < 74) begin
            send_access(FUNC_READ, 24'($urandom), 8'($urandom));
         end else if (pick < 80) begin
            if (pick[0]) send_access(FUNC_WRITE, 24'($urandom), CMD_RESET);
            else issue_command(CMD_RESET);
         end else if (pick < 90) begin
            // start an unlock and spoil it partway
            send_access(FUNC_WRITE, {command_page(), ADDR_UNLOCK_A}, DATA_UNLOCK_A);
            if (pick[0]) begin
               send_access(FUNC_WRITE, 24'($urandom), 8'($urandom));
            end else begin
               send_access(FUNC_WRITE, {command_page(), ADDR_UNLOCK_B}, DATA_UNLOCK_B);
               send_access(FUNC_WRITE, {command_page(), ADDR_UNLOCK_A}, 8'($urandom));
            end
         end else begin
            send_access(($urandom_range(3) == 0) ? FUNC_READ : FUNC_WRITE,
                        24'($urandom), 8'($urandom));
         end
      end
   endtask

   initial begin
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      reset      <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed beats on the reset configuration.
      issue_command(CMD_READ_ID);
      send_access(FUNC_READ, 24'h000000, 8'h00);
      send_access(FUNC_READ, 24'hFFFFFF, 8'hFF);
      // reset byte outside any sequence still flags a save
      send_access(FUNC_WRITE, 24'h123456, CMD_RESET);
      // program the last byte of chip one, in the top boot sub-block
      issue_command(CMD_PROGRAM);
      send_access(FUNC_WRITE, 24'h9FFFFF, 8'h00);
      // program outside both windows: dropped
      issue_command(CMD_PROGRAM);
      send_access(FUNC_WRITE, 24'h000100, 8'hFF);
      // erase of block zero: dropped
      issue_command(CMD_SETUP_ERASE);
      unlock();
      send_access(FUNC_WRITE, 24'h001234, CMD_BLOCK_ERASE_A);
      // chip erase: accepted, no action
      issue_command(CMD_SETUP_ERASE);
      unlock();
      send_access(FUNC_WRITE, {8'h00, ADDR_UNLOCK_A}, CMD_CHIP_ERASE);
      // erase of an 8k boot sub-block of chip one
      issue_command(CMD_SETUP_ERASE);
      unlock();
      send_access(FUNC_WRITE, 24'hFFA000, CMD_BLOCK_ERASE_B);
      run_random(PHASE_BEATS);

      // Low extremes, boot area at block zero, no second chip.
      drain();
      configure(8'h00, 8'hFF, 5'd0, 1'b0);
      // a write into the dead upper window is skipped; the next one is the target
      issue_command(CMD_PROGRAM);
      send_access(FUNC_WRITE, 24'h812345, 8'h5A);
      send_access(FUNC_WRITE, 24'h2FFFFF, 8'hA5);
      run_random(PHASE_BEATS);

      // High extremes; hold the receiver off while the sender keeps pushing.
      drain();
      configure(8'hFF, 8'h00, 5'd1, 1'b1);
      hold_rsp = 1'b1;
      run_random(PHASE_BEATS);

      // Random setting, back-to-back beats with no idling on either side.
      drain();
      configure(8'($urandom), 8'($urandom), 5'($urandom_range(2, 30)), 1'b1);
      no_idle = 1'b1;
      run_random(PHASE_BEATS);
      no_idle = 1'b0;

      // Top boot position with the second chip gone.
      drain();
      configure(8'($urandom), 8'($urandom), 5'd31, 1'b0);
      run_random(PHASE_BEATS);

      // Mid boot position: erase a 64k block numbered past the boot start.
      drain();
      configure(8'($urandom), 8'($urandom), 5'd15, 1'b1);
      issue_command(CMD_SETUP_ERASE);
      unlock();
      send_access(FUNC_WRITE, 24'h140000, CMD_BLOCK_ERASE_A);
      run_random(PHASE_BEATS);

      drain();
      repeat (8) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/flsq_pkg.sv
rtl/flsq_erase_mark.sv
rtl/flsq_seq.sv
rtl/flash_command_sequencer.sv
verif/testbench.sv
